>>> hw/rtl/pti_pkg.sv
package pti_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [1:0] {
        CMD_SPAWN = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SPAWN, S_RD, S_RDW, S_TICK, S_DRAIN, S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] size_w;
        logic [31:0] size_h;
        logic [31:0] lifetime;
        logic [31:0] elapsed;
        logic [5:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  live_count;
        logic        accepted;
        logic [31:0] out_pos_x;
        logic [31:0] out_pos_y;
        logic [31:0] out_pos_z;
        logic [31:0] out_vel_x;
        logic [31:0] out_vel_y;
        logic [31:0] out_vel_z;
        logic [31:0] out_size_w;
        logic [31:0] out_size_h;
        logic [31:0] out_age;
        logic [31:0] out_life;
    } t_out_item;

    // one table row
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] sw;
        logic [31:0] sh;
        logic [31:0] age;
        logic [31:0] life;
    } t_entry;

    typedef struct packed {
        logic latch;
        logic spawn_wr;
        logic tk_start;
        logic tk_issue;
        logic tk_end;
        logic resp_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       k_done;
        logic       pipe_busy;
        logic       out_free;
    } t_dp_sts;

    // magnitude of a signed 32-bit value
    function automatic logic [31:0] abs32(input logic [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    // pos + floor(prod/65536) with sign, saturated to signed 32 bits
    function automatic logic [31:0] adv(input logic [31:0] pos, input logic neg,
                                        input logic [63:0] prod);
        logic [48:0] d;
        logic [49:0] s;
        logic [49:0] dd;
        logic [31:0] r;
        d  = neg ? 49'((65'(prod) + 65'd65535) >> 16) : 49'(prod >> 16);
        dd = neg ? (~{1'b0, d} + 50'd1) : {1'b0, d};
        s  = {{18{pos[31]}}, pos} + dd;
        if (!s[49] && (s[48:31] != 18'd0))
            r = 32'h7FFF_FFFF;
        else if (s[49] && (s[48:31] != 18'h3FFFF))
            r = 32'h8000_0000;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/pti_stream_if.sv
interface pti_in_if;
    import pti_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pti_out_if;
    import pti_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/particle_table_integrator.sv
// Particle table of up to MAX_PARTICLES entries. Spawn appends a particle,
// tick ages all particles, drops expired ones with order kept and advances
// the survivors' positions, read returns one entry; every result carries the
// live count. One item is in work at a time. Tick sweeps the table through a
// three-stage pipeline, reading one entry per cycle and writing each surviving entry
// back. A finished result waits in the output register while the next
// item is taken.
module particle_table_integrator (
    input  logic i_clk,
    input  logic i_rst_n,
    pti_in_if.sink    i_in,
    pti_out_if.source o_out
);
    import pti_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    pti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pti_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in.data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.data)
    );
endmodule

>>> hw/rtl/pti_ctrl.sv
module pti_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pti_pkg::t_dp_sts i_sts,
    output pti_pkg::t_dp_cmd o_cmd
);
    import pti_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                unique case (t_cmd'(i_sts.cmd))
                    CMD_SPAWN: n_state = S_SPAWN;
                    CMD_TICK: begin
                        o_cmd.tk_start = 1'b1;
                        n_state        = S_TICK;
                    end
                    CMD_READ: n_state = S_RD;
                    default:  n_state = S_RESP;
                endcase
            end
            S_SPAWN: begin
                o_cmd.spawn_wr = 1'b1;
                n_state        = S_RESP;
            end
            S_RD:  n_state = S_RDW;
            S_RDW: n_state = S_RESP;
            S_TICK: begin
                if (i_sts.k_done) n_state = S_DRAIN;
                else              o_cmd.tk_issue = 1'b1;
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.tk_end = 1'b1;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> hw/rtl/pti_dp.sv
module pti_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pti_pkg::t_in_item  i_item,
    input  pti_pkg::t_dp_cmd   i_cmd,
    output pti_pkg::t_dp_sts   o_sts,
    output logic               o_valid,
    input  logic               i_ready,
    output pti_pkg::t_out_item o_item
);
    import pti_pkg::*;

    t_entry          mem [MAX_PARTICLES];
    t_in_item        r_item;
    logic [CW-1:0]   r_count, r_k, r_w;
    logic            r_acc;
    t_entry          r_rd;
    logic            r_v1, r_v2, r_keep;
    t_entry          r_e2;
    logic [63:0]     r_mx, r_my, r_mz;
    logic            r_valid;
    t_out_item       r_out;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    t_entry          wr_data, spawn_e, tick_e;
    t_entry          st1_e;
    logic [32:0]     age_sum;
    logic [31:0]     age_sat;
    logic            rd_ok;
    t_out_item       res;

    // table read: tick sweep or read index
    assign rd_addr = i_cmd.tk_issue ? r_k[AW-1:0] : r_item.read_index[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    // latch the command item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_item;
    end

    // stage one: age update and products
    assign age_sum = {1'b0, r_rd.age} + {1'b0, r_item.elapsed};
    assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];

    always_comb begin
        st1_e     = r_rd;
        st1_e.age = age_sat;
    end

    always_ff @(posedge i_clk) begin
        r_keep <= age_sat < r_rd.life;
        r_e2   <= st1_e;
        r_mx   <= abs32(r_rd.vx) * r_item.elapsed;
        r_my   <= abs32(r_rd.vy) * r_item.elapsed;
        r_mz   <= abs32(r_rd.vz) * r_item.elapsed;
    end

    // stage two: new positions, compacted write
    always_comb begin
        tick_e    = r_e2;
        tick_e.px = adv(r_e2.px, r_e2.vx[31], r_mx);
        tick_e.py = adv(r_e2.py, r_e2.vy[31], r_my);
        tick_e.pz = adv(r_e2.pz, r_e2.vz[31], r_mz);
    end

    always_comb begin
        spawn_e = '{px: r_item.pos_x, py: r_item.pos_y, pz: r_item.pos_z,
                    vx: r_item.vel_x, vy: r_item.vel_y, vz: r_item.vel_z,
                    sw: r_item.size_w, sh: r_item.size_h, age: 32'd0,
                    life: r_item.lifetime};
    end

    always_comb begin
        if (i_cmd.spawn_wr) begin
            wr_en   = r_count < CW'(MAX_PARTICLES);
            wr_addr = r_count[AW-1:0];
            wr_data = spawn_e;
        end else begin
            wr_en   = r_v2 && r_keep;
            wr_addr = r_w[AW-1:0];
            wr_data = tick_e;
        end
    end

    // control registers: count, sweep pointers, pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_k     <= '0;
            r_w     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_acc   <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tk_issue;
            r_v2 <= r_v1;
            if (i_cmd.latch) r_acc <= 1'b0;
            if (i_cmd.spawn_wr && r_count < CW'(MAX_PARTICLES)) begin
                r_count <= r_count + CW'(1);
                r_acc   <= 1'b1;
            end
            if (i_cmd.tk_start) begin
                r_k <= '0;
                r_w <= '0;
            end
            if (i_cmd.tk_issue) r_k <= r_k + CW'(1);
            if (!i_cmd.spawn_wr && r_v2 && r_keep) r_w <= r_w + CW'(1);
            if (i_cmd.tk_end) r_count <= r_w;
        end
    end

    // result assembly
    assign rd_ok = (t_cmd'(r_item.cmd) == CMD_READ) &&
                   (CW'(r_item.read_index) < r_count);

    always_comb begin
        res            = '0;
        res.live_count = 7'(r_count);
        res.accepted   = rd_ok || r_acc;
        if (rd_ok) begin
            res.out_pos_x  = r_rd.px;
            res.out_pos_y  = r_rd.py;
            res.out_pos_z  = r_rd.pz;
            res.out_vel_x  = r_rd.vx;
            res.out_vel_y  = r_rd.vy;
            res.out_vel_z  = r_rd.vz;
            res.out_size_w = r_rd.sw;
            res.out_size_h = r_rd.sh;
            res.out_age    = r_rd.age;
            res.out_life   = r_rd.life;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (i_cmd.resp_load) r_valid <= 1'b1;
        else if (i_ready) r_valid <= 1'b0;
        if (i_cmd.resp_load) r_out <= res;
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

    assign o_sts.cmd       = r_item.cmd;
    assign o_sts.k_done    = r_k >= r_count;
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = !r_valid || i_ready;
endmodule
